### design/hashed_timer_wheel_assert.svh
// ----------------------------------------------------------------------------
// hashed_timer_wheel_assert
// Assertion macros used by the wheel module.
// ----------------------------------------------------------------------------
`ifndef HASHED_TIMER_WHEEL_ASSERT_SVH
`define HASHED_TIMER_WHEEL_ASSERT_SVH
// implication check with synchronous reset disable
`define HTW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication check
`define HTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### design/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg
// Types and constants of the hashed timer wheel.
// ----------------------------------------------------------------------------
package htw_pkg;
   localparam int WHEEL_SLOTS_DEF = 256;
   localparam int NUM_TIMERS_DEF  = 32;
   localparam int MS_W    = 32;
   localparam int TLEN_W  = 16;
   localparam int ID_W    = 5;
   localparam int CMD_W   = 2;

   localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STOP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // control word given to every cell of the row each cycle
   typedef struct packed {
      logic       shift;   // rotate cell contents by one position
   } ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_ARM   = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_STOP  = 5'b10000
   } state_type;
endpackage

### design/htw_div.sv
// ----------------------------------------------------------------------------
// htw_div
// Bit-serial ceiling division of two millisecond values by the tick length.
// ----------------------------------------------------------------------------
module htw_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [htw_pkg::MS_W-1:0]      dly_ms,
   input  logic [htw_pkg::MS_W-1:0]      per_ms,
   input  logic [htw_pkg::TLEN_W-1:0]    divisor,
   output logic                          done,
   output logic [htw_pkg::MS_W-1:0]      dly_ticks,
   output logic [htw_pkg::MS_W-1:0]      per_ticks
);
   localparam int W  = htw_pkg::MS_W;
   localparam int DW = htw_pkg::TLEN_W;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]    qa_ff, qa_in, qb_ff, qb_in;
   logic [DW:0]     ra_ff, ra_in, rb_ff, rb_in;
   logic [DW-1:0]   d_ff, d_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic [DW:0]     ta, tb;

   always_comb begin
      qa_in = qa_ff; qb_in = qb_ff; ra_in = ra_ff; rb_in = rb_ff;
      d_in = d_ff; cnt_in = cnt_ff; run_in = run_ff;
      ta = '0; tb = '0;
      if (go) begin
         qa_in = dly_ms; qb_in = per_ms; ra_in = '0; rb_in = '0;
         d_in = (divisor == '0) ? DW'(1) : divisor;
         cnt_in = CW'(W); run_in = 1'b1;
      end else if (run_ff) begin
         ta = {ra_ff[DW-1:0], qa_ff[W-1]};
         tb = {rb_ff[DW-1:0], qb_ff[W-1]};
         if (ta >= {1'b0, d_ff}) begin
            ra_in = ta - {1'b0, d_ff}; qa_in = {qa_ff[W-2:0], 1'b1};
         end else begin
            ra_in = ta; qa_in = {qa_ff[W-2:0], 1'b0};
         end
         if (tb >= {1'b0, d_ff}) begin
            rb_in = tb - {1'b0, d_ff}; qb_in = {qb_ff[W-2:0], 1'b1};
         end else begin
            rb_in = tb; qb_in = {qb_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      qa_ff <= qa_in; qb_ff <= qb_in; ra_ff <= ra_in; rb_ff <= rb_in; d_ff <= d_in;
   end

   // quotient of at most 2^32-1 plus one for a remainder never overflows 32 bits
   // except when divisor is 1, where the remainder is zero
   assign done      = run_ff && (cnt_ff == CW'(1)) && !go;
   assign dly_ticks = qa_in + W'(ra_in != '0);
   assign per_ticks = qb_in + W'(rb_in != '0);
endmodule

### design/htw_cell.sv
// ----------------------------------------------------------------------------
// htw_cell
// One timer of the rotating row: active flag, slot, rounds and period.
// ----------------------------------------------------------------------------
module htw_cell #(
   parameter int SLOT_W = 8,
   parameter int RND_W  = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  htw_pkg::ctl_type           ctl,
   input  logic                       act_prev,
   input  logic [SLOT_W-1:0]          slot_prev,
   input  logic [RND_W-1:0]           rnd_prev,
   input  logic [htw_pkg::MS_W-1:0]   per_prev,
   output logic                       act_q,
   output logic [SLOT_W-1:0]          slot_q,
   output logic [RND_W-1:0]           rnd_q,
   output logic [htw_pkg::MS_W-1:0]   per_q
);
   logic                      act_ff, act_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [RND_W-1:0]          rnd_ff, rnd_in;
   logic [htw_pkg::MS_W-1:0]  per_ff, per_in;

   always_comb begin
      act_in = act_ff; slot_in = slot_ff; rnd_in = rnd_ff; per_in = per_ff;
      if (ctl.shift) begin
         act_in = act_prev; slot_in = slot_prev; rnd_in = rnd_prev; per_in = per_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
      slot_ff <= slot_in; rnd_ff <= rnd_in; per_ff <= per_in;
   end

   assign act_q  = act_ff;
   assign slot_q = slot_ff;
   assign rnd_q  = rnd_ff;
   assign per_q  = per_ff;
endmodule

### design/hashed_timer_wheel.sv
// ----------------------------------------------------------------------------
// hashed_timer_wheel
// Timing wheel of fixed-id timers held in a rotating row of timer cells.
// ----------------------------------------------------------------------------
// Usage:
//  Input: drive req_start with req_command/req_timer_id/req_delay_ms/
//  req_period_ms; the transfer takes place on an edge where req_busy is low.
//  Start converts both times with a 32-step bit-serial divider and then
//  rotates the timer row once. Stop and tick rotate the row once. Every
//  timer passes the tail cell once per rotation, in ascending id order;
//  one command is handled at a time.
//  Results: rsp_strobe marks one cycle with rsp_expired_id and
//  rsp_last_of_run. Expiries leave in ascending id order, each held until
//  the next is found; the last one is flushed once the controller is idle
//  again and leaves in the cycle where req_busy drops. The receiver cannot stall.
//  csr_write_enable/csr_write_data set the tick length; write while idle.
//  Reset: synchronous, clears all timers, slot 0, tick length 1.
// ----------------------------------------------------------------------------
`include "hashed_timer_wheel_assert.svh"
module hashed_timer_wheel #(
   parameter int NUM_TIMERS  = htw_pkg::NUM_TIMERS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_start,
   output logic                         req_busy,
   input  logic [htw_pkg::CMD_W-1:0]    req_command,
   input  logic [htw_pkg::ID_W-1:0]     req_timer_id,
   input  logic [htw_pkg::MS_W-1:0]     req_delay_ms,
   input  logic [htw_pkg::MS_W-1:0]     req_period_ms,
   output logic                         rsp_strobe,
   output logic [htw_pkg::ID_W-1:0]     rsp_expired_id,
   output logic                         rsp_last_of_run,
   input  logic                         csr_write_enable,
   input  logic [htw_pkg::TLEN_W-1:0]   csr_write_data
);
   localparam int WHEEL_SLOTS = htw_pkg::WHEEL_SLOTS_DEF;
   localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
   localparam int MS_W   = htw_pkg::MS_W;
   localparam int RND_W  = MS_W - SLOT_W;
   localparam int ID_W   = htw_pkg::ID_W;
   localparam int CW     = $clog2(NUM_TIMERS + 1);
   localparam logic [MS_W:0] SLOTS_EXT = (MS_W+1)'(WHEEL_SLOTS);

   htw_pkg::state_type        st_ff, st_in;
   htw_pkg::ctl_type          ctl;
   logic [htw_pkg::TLEN_W-1:0] tlen_ff, tlen_in;
   logic [SLOT_W-1:0]         cur_ff, cur_in;
   logic [ID_W-1:0]           id_ff, id_in;
   logic [MS_W-1:0]           dly_ff, dly_in, per_ff, per_in;
   logic [CW-1:0]             pos_ff, pos_in;
   logic                      zero_ff, zero_in;
   logic                      div_go, div_done;
   logic [MS_W-1:0]           div_dly, div_per;
   logic                      pend_ff, pend_in;
   logic [ID_W-1:0]           pend_id_ff, pend_id_in;
   logic                      out_v_ff, out_v_in, out_l_ff, out_l_in;
   logic [ID_W-1:0]           out_id_ff, out_id_in;

   logic                      act_q [NUM_TIMERS];
   logic [SLOT_W-1:0]         slot_q [NUM_TIMERS];
   logic [RND_W-1:0]          rnd_q [NUM_TIMERS];
   logic [MS_W-1:0]           prd_q [NUM_TIMERS];

   // head feedback: the value that enters cell 0 from the last cell, edited
   logic                      h_act;
   logic [SLOT_W-1:0]         h_slot;
   logic [RND_W-1:0]          h_rnd;
   logic [MS_W-1:0]           h_per;
   logic                      hit, arm_now;
   logic [MS_W-1:0]           arm_t, arm_tm1;
   logic [ID_W-1:0]           pos_id;

   htw_div u_div (
      .clock(clock), .reset(reset), .go(div_go), .dly_ms(req_delay_ms),
      .per_ms(req_period_ms), .divisor(tlen_ff), .done(div_done),
      .dly_ticks(div_dly), .per_ticks(div_per)
   );

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      if (g == 0) begin : g_head
         htw_cell #(.SLOT_W(SLOT_W), .RND_W(RND_W)) u_cell (
            .clock(clock), .reset(reset), .ctl(ctl),
            .act_prev(h_act), .slot_prev(h_slot), .rnd_prev(h_rnd), .per_prev(h_per),
            .act_q(act_q[g]), .slot_q(slot_q[g]), .rnd_q(rnd_q[g]), .per_q(prd_q[g])
         );
      end else begin : g_body
         htw_cell #(.SLOT_W(SLOT_W), .RND_W(RND_W)) u_cell (
            .clock(clock), .reset(reset), .ctl(ctl),
            .act_prev(act_q[g-1]), .slot_prev(slot_q[g-1]), .rnd_prev(rnd_q[g-1]),
            .per_prev(prd_q[g-1]),
            .act_q(act_q[g]), .slot_q(slot_q[g]), .rnd_q(rnd_q[g]), .per_q(prd_q[g])
         );
      end
   end

   assign pos_id = ID_W'(pos_ff);
   assign arm_tm1 = arm_t - MS_W'(1);

   // the last cell holds timer pos_ff while rotating; it feeds cell 0, and a
   // full turn of NUM_TIMERS shifts brings every timer back to its rest cell
   logic [ID_W-1:0] tail_id;
   assign tail_id = pos_id;

   always_comb begin
      h_act  = act_q[NUM_TIMERS-1];
      h_slot = slot_q[NUM_TIMERS-1];
      h_rnd  = rnd_q[NUM_TIMERS-1];
      h_per  = prd_q[NUM_TIMERS-1];
      hit = 1'b0; arm_now = 1'b0; arm_t = h_per;
      if (st_ff == htw_pkg::ST_SCAN) begin
         if (h_act && h_slot == cur_ff) begin
            if (h_rnd != '0) begin
               h_rnd = h_rnd - RND_W'(1);
            end else begin
               hit = 1'b1; h_act = 1'b0;
               if (h_per != '0) begin
                  arm_now = 1'b1;
               end
            end
         end
      end else if (st_ff == htw_pkg::ST_STOP && tail_id == id_ff) begin
         h_act = 1'b0;
      end else if (st_ff == htw_pkg::ST_ARM && tail_id == id_ff) begin
         h_per = per_ff; h_act = 1'b0;
         if (dly_ff != '0) begin
            arm_t = dly_ff; arm_now = 1'b1;
         end else if (per_ff != '0) begin
            arm_t = per_ff; arm_now = 1'b1;
         end
      end
      if (arm_now) begin
         h_act  = 1'b1;
         h_rnd  = arm_tm1[MS_W-1:SLOT_W];
         h_slot = cur_ff + arm_t[SLOT_W-1:0];
      end
   end

   always_comb begin
      st_in = st_ff; tlen_in = tlen_ff; cur_in = cur_ff;
      id_in = id_ff; dly_in = dly_ff; per_in = per_ff; pos_in = pos_ff;
      zero_in = zero_ff; div_go = 1'b0; ctl = '0;
      pend_in = pend_ff; pend_id_in = pend_id_ff;
      out_v_in = 1'b0; out_l_in = 1'b0; out_id_in = out_id_ff;
      if (csr_write_enable) begin
         tlen_in = csr_write_data;
      end
      unique case (st_ff) inside
         htw_pkg::ST_IDLE: begin
            if (req_start && !pend_ff) begin
               id_in = req_timer_id;
               dly_in = req_delay_ms; per_in = req_period_ms; pos_in = '0;
               pend_in = 1'b0;
               if (req_command == htw_pkg::CMD_START &&
                   32'(req_timer_id) < NUM_TIMERS) begin
                  st_in = htw_pkg::ST_DIV; div_go = 1'b1;
               end else if (req_command == htw_pkg::CMD_STOP &&
                   32'(req_timer_id) < NUM_TIMERS) begin
                  st_in = htw_pkg::ST_STOP;
               end else if (req_command == htw_pkg::CMD_TICK) begin
                  st_in = htw_pkg::ST_SCAN;
                  cur_in = SLOT_W'((MS_W+1)'(cur_ff) + (MS_W+1)'(1) == SLOTS_EXT ?
                                   '0 : cur_ff + SLOT_W'(1));
               end
            end
         end
         htw_pkg::ST_DIV: begin
            if (div_done) begin
               dly_in = div_dly; per_in = div_per; st_in = htw_pkg::ST_ARM;
               zero_in = (div_dly == '0);
            end
         end
         htw_pkg::ST_ARM, htw_pkg::ST_STOP, htw_pkg::ST_SCAN: begin
            ctl.shift = 1'b1;
            pos_in = pos_ff + CW'(1);
            if (hit) begin
               if (pend_ff) begin
                  out_v_in = 1'b1; out_id_in = pend_id_ff;
               end
               pend_in = 1'b1; pend_id_in = tail_id;
            end
            if (st_ff == htw_pkg::ST_ARM && tail_id == id_ff && zero_ff) begin
               pend_in = 1'b1; pend_id_in = id_ff;
            end
            if (pos_ff == CW'(NUM_TIMERS - 1)) begin
               st_in = htw_pkg::ST_IDLE;
            end
         end
         default: st_in = htw_pkg::ST_IDLE;
      endcase
      // flush the held expiry as last once rotation is over
      if (st_ff == htw_pkg::ST_IDLE && pend_ff) begin
         out_v_in = 1'b1; out_l_in = 1'b1; out_id_in = pend_id_ff; pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= htw_pkg::ST_IDLE;
         tlen_ff <= htw_pkg::TLEN_W'(1);
         cur_ff <= '0;
         pos_ff <= '0;
         pend_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         tlen_ff <= tlen_in;
         cur_ff <= cur_in;
         pos_ff <= pos_in;
         pend_ff <= pend_in;
         out_v_ff <= out_v_in;
      end
      id_ff <= id_in; dly_ff <= dly_in; per_ff <= per_in;
      zero_ff <= zero_in; pend_id_ff <= pend_id_in;
      out_l_ff <= out_l_in; out_id_ff <= out_id_in;
   end

   assign req_busy        = (st_ff != htw_pkg::ST_IDLE) || pend_ff;
   assign rsp_strobe      = out_v_ff;
   assign rsp_expired_id  = out_id_ff;
   assign rsp_last_of_run = out_l_ff;

   `HTW_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe && !rsp_last_of_run, req_busy, "non-final expiry while idle")
   `HTW_ASSERT_NEXT(a_div_arm, clock, reset, st_ff == htw_pkg::ST_DIV && div_done, st_ff == htw_pkg::ST_ARM, "divider done without arm")
   `HTW_ASSERT_IMP(a_pos_range, clock, reset, st_ff != htw_pkg::ST_IDLE, 32'(pos_ff) < NUM_TIMERS, "row position out of range")
endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_timer_wheel testbench
// Drives start, stop, tick and unused commands with random gaps, predicts
// expiries with a behavioral timing wheel and checks each expired id and last flag in order.
// ----------------------------------------------------------------------------
typedef struct packed {
   logic [htw_pkg::ID_W-1:0] expired_id;
   logic                     last_of_run;
} expiry_type;

class expiry_scoreboard;
   logic [htw_pkg::TLEN_W-1:0] tick_len;
   logic [7:0]        slot_now;
   bit                active [32];
   logic [7:0]        tslot [32];
   logic [31:0]       rounds [32];
   logic [31:0]       period [32];
   expiry_type        pending [$];
   int                errors;

   function new();
      tick_len = htw_pkg::TLEN_W'(1);
      slot_now = '0;
      errors = 0;
      foreach (active[i]) active[i] = 0;
   endfunction

   function logic [31:0] to_tick_count(logic [31:0] ms);
      logic [31:0] d;
      logic [31:0] t;
      d = (tick_len == 0) ? 32'd1 : {16'd0, tick_len};
      if (ms == 0) return 0;
      t = ms / d;
      if (ms % d != 0) t++;
      return t;
   endfunction

   function void place(int id, logic [31:0] t);
      rounds[id] = (t - 1) / 256;
      tslot[id] = slot_now + t[7:0];
      active[id] = 1;
   endfunction

   function void note_transfer(logic [htw_pkg::CMD_W-1:0] cmd,
                               logic [htw_pkg::ID_W-1:0] id,
                               logic [31:0] dly, logic [31:0] per);
      logic [31:0] dt;
      int n;
      expiry_type e;
      n = 0;
      if (cmd == htw_pkg::CMD_START) begin
         dt = to_tick_count(dly);
         period[id] = to_tick_count(per);
         active[id] = 0;
         if (dt != 0) begin
            place(id, dt);
         end else begin
            e.expired_id = id;
            e.last_of_run = 1;
            pending.push_back(e);
            if (period[id] != 0) place(id, period[id]);
         end
      end else if (cmd == htw_pkg::CMD_STOP) begin
         active[id] = 0;
      end else if (cmd == htw_pkg::CMD_TICK) begin
         slot_now++;
         for (int i = 0; i < 32; i++) begin
            if (!active[i] || tslot[i] != slot_now) continue;
            if (rounds[i] > 0) begin
               rounds[i]--;
               continue;
            end
            e.expired_id = htw_pkg::ID_W'(i);
            e.last_of_run = 0;
            pending.push_back(e);
            n++;
            active[i] = 0;
            if (period[i] != 0) place(i, period[i]);
         end
         if (n > 0) pending[pending.size() - 1].last_of_run = 1;
      end
   endfunction

   function void check_expiry(logic [htw_pkg::ID_W-1:0] id, logic last);
      expiry_type e;
      if (pending.size() == 0) begin
         $error("unexpected expiry id=%0d last=%0d", id, last);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (id !== e.expired_id) begin
         $error("expired_id expected %0d actual %0d", e.expired_id, id);
         errors++;
      end
      if (last !== e.last_of_run) begin
         $error("last_of_run expected %0d actual %0d", e.last_of_run, last);
         errors++;
      end
   endfunction
endclass

module testbench;
   logic                        clock = 0;
   logic                        reset = 1;
   logic                        req_start = 0;
   logic                        req_busy;
   logic [htw_pkg::CMD_W-1:0]   req_command = htw_pkg::CMD_TICK;
   logic [htw_pkg::ID_W-1:0]    req_timer_id = 0;
   logic [htw_pkg::MS_W-1:0]    req_delay_ms = 0;
   logic [htw_pkg::MS_W-1:0]    req_period_ms = 0;
   logic                        rsp_strobe;
   logic [htw_pkg::ID_W-1:0]    rsp_expired_id;
   logic                        rsp_last_of_run;
   logic                        csr_write_enable = 0;
   logic [htw_pkg::TLEN_W-1:0]  csr_write_data = 0;

   expiry_scoreboard sb = new();
   int  quiet_cycles = 0;
   bit  calm = 0;
   localparam int WATCHDOG = 20000;

   hashed_timer_wheel uut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_expiry(rsp_expired_id, rsp_last_of_run);
      if (reset || (req_start && !req_busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("testbench: errors");
         $finish;
      end
   end

   task automatic send(logic [htw_pkg::CMD_W-1:0] cmd, logic [htw_pkg::ID_W-1:0] id,
                       logic [31:0] dly, logic [31:0] per);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_start <= 0;
         repeat (gap) @(posedge clock);
      end
      req_start <= 1;
      req_command <= cmd;
      req_timer_id <= id;
      req_delay_ms <= dly;
      req_period_ms <= per;
      @(posedge clock);
      while (req_busy) @(posedge clock);
      sb.note_transfer(cmd, id, dly, per);
   endtask

   task automatic drain();
      req_start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_tick_len(logic [htw_pkg::TLEN_W-1:0] v);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.tick_len = v;
   endtask

   function automatic logic [31:0] rand_ms();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return $urandom();
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   task automatic random_phase(int count);
      int r;
      logic [htw_pkg::ID_W-1:0] rid;
      logic [31:0] ra;
      logic [31:0] rb;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 9);
         rid = htw_pkg::ID_W'($urandom());
         ra = $urandom();
         rb = $urandom();
         if (r < 5) send(htw_pkg::CMD_TICK, rid, ra, rb);
         else if (r < 8) send(htw_pkg::CMD_START, rid, rand_ms(),
                              ($urandom_range(0, 1) ? rand_ms() : 0));
         else if (r < 9) send(htw_pkg::CMD_STOP, rid, ra, rb);
         else send(htw_pkg::CMD_UNUSED, rid, ra, rb);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_tick_len(1);
      send(htw_pkg::CMD_START, 0, 0, 0);
      send(htw_pkg::CMD_START, 31, 0, 3);
      send(htw_pkg::CMD_START, 5, 256, 0);
      send(htw_pkg::CMD_START, 6, 512, 0);
      send(htw_pkg::CMD_START, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(htw_pkg::CMD_START, 8, 1, 1);
      send(htw_pkg::CMD_STOP, 9, 0, 0);
      send(htw_pkg::CMD_STOP, 7, 0, 0);
      send(htw_pkg::CMD_UNUSED, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int k = 0; k < 4; k++) send(htw_pkg::CMD_TICK, 0, 0, 0);
      for (int k = 0; k < 32; k++) send(htw_pkg::CMD_START, htw_pkg::ID_W'(k), 2, 0);
      send(htw_pkg::CMD_TICK, 0, 0, 0);
      send(htw_pkg::CMD_TICK, 0, 0, 0);
      for (int k = 0; k < 4; k++) send(htw_pkg::CMD_STOP, htw_pkg::ID_W'(28 + k), 0, 0);
      write_tick_len(0);
      random_phase(25);
      write_tick_len(16'hFFFF);
      send(htw_pkg::CMD_START, 3, 32'h0001_0000, 0);
      random_phase(20);
      write_tick_len(3);
      random_phase(25);
      for (int k = 0; k < 20; k++) send(htw_pkg::CMD_TICK, 0, 0, 0);
      write_tick_len(1);
      calm = 1;
      random_phase(20);
      drain();
      if (sb.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+design
design/htw_pkg.sv
design/htw_div.sv
design/htw_cell.sv
design/hashed_timer_wheel.sv
tb/testbench.sv
